>>> sv/clmu_pkg.sv
// Shared types and constants for the chain joint length matcher.
// Used by the top level, clmu_dist and clmu_checker; depends on nothing.
`default_nettype none
package clmu_pkg;

    localparam int MAX_JOINTS = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int LEN_W      = 16;
    // Cumulative lengths and chain totals: one length plus index growth.
    localparam int CUM_W      = LEN_W + IDX_W;
    localparam int PROD_W     = 2 * CUM_W;

    typedef enum logic [1:0] {
        OP_LOAD_SRC = 2'd0,
        OP_LOAD_TGT = 2'd1,
        OP_QUERY    = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GREEDY,
        ST_LEFT,
        ST_FINISH
    } state_t;

    // Tag that travels with one (target, source) pair through the scan.
    typedef struct packed {
        logic             live;
        logic             consider;
        logic             first;
        logic             endj;
        logic             fin;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } tag_t;

    // Result of one scan group: best pair found so far at its end.
    typedef struct packed {
        logic             v;
        logic             fin;
        logic             found;
        logic [IDX_W-1:0] bi;
        logic [IDX_W-1:0] bj;
        logic [IDX_W-1:0] j;
    } scan_ev_t;

endpackage
`default_nettype wire

>>> sv/chain_joint_length_matcher_unit.sv
// Top level of the chain joint length matcher: command port, control, RAMs.
// Depends on clmu_pkg, clmu_ram and clmu_dist.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-------------------
//  command | operation, segment_length, query_target          | start high, busy low
//  result  | joint_index, empty_res, error, last              | done, one cycle
//
// Loads, clears, errors and queries on chains of equal count answer in the
// cycle after the word is taken, and the block takes the next word at once.
// Other queries scan all pairs through the two RAM read ports, one pair a
// cycle, once per greedy round and once more for the unmatched sources;
// busy holds meanwhile. Reset clears counts and totals; the RAMs need no clearing.
// Results cannot be stalled; each word shows on done for one cycle.
`default_nettype none
module chain_joint_length_matcher_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  operation,
    input  wire logic [clmu_pkg::LEN_W-1:0]  segment_length,
    input  wire logic [clmu_pkg::IDX_W-1:0]  query_target,
    output logic                             done,
    output logic [clmu_pkg::IDX_W-1:0]       joint_index,
    output logic                             empty_res,
    output logic                             error,
    output logic                             last
);

    localparam int MJ = clmu_pkg::MAX_JOINTS;
    localparam int IW = clmu_pkg::IDX_W;
    localparam int CW = clmu_pkg::CNT_W;
    localparam int UW = clmu_pkg::CUM_W;

    clmu_pkg::state_t   state_reg;
    clmu_pkg::state_t   state_next;
    logic               issuing_reg, issuing_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [CW-1:0]      round_reg, round_next;
    logic [MJ-1:0]      tm_reg, tm_next;
    logic [MJ-1:0]      us_reg, us_next;
    logic               qhas_reg, qhas_next;
    logic [IW-1:0]      qsrc_reg, qsrc_next;
    logic               pend_v_reg, pend_v_next;
    logic [IW-1:0]      pend_idx_reg, pend_idx_next;
    logic [IW-1:0]      q_reg, q_next;
    logic               szero_reg, szero_next;
    logic               tzero_reg, tzero_next;
    logic [CW-1:0]      src_cnt_reg, src_cnt_next;
    logic [CW-1:0]      tgt_cnt_reg, tgt_cnt_next;
    logic [UW-1:0]      src_tot_reg, src_tot_next;
    logic [UW-1:0]      tgt_tot_reg, tgt_tot_next;
    clmu_pkg::tag_t     tag_reg, tag_next;
    logic               done_reg, done_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               empty_reg, empty_next;
    logic               err_reg, err_next;
    logic               last_reg, last_next;

    logic               accept;
    clmu_pkg::op_t      op;
    logic [UW-1:0]      len_ext;
    logic [CW-1:0]      rounds;
    logic [CW-1:0]      ns_m1, nt_m1;
    logic               i_last, j_last;
    logic               src_we, tgt_we;
    logic [UW-1:0]      src_rdata, tgt_rdata;
    logic [UW-1:0]      ct_in, cs_in;
    logic [UW-1:0]      s_eff, t_eff;
    clmu_pkg::scan_ev_t ev;
    logic               push_v;
    logic [IW-1:0]      push_idx;
    logic               greedy_end;
    logic               query_bad;

    assign accept  = start && (state_reg == clmu_pkg::ST_IDLE);
    assign busy    = (state_reg != clmu_pkg::ST_IDLE);
    assign op      = clmu_pkg::op_t'(operation);
    assign len_ext = {{(UW - clmu_pkg::LEN_W){1'b0}}, segment_length};
    assign rounds  = (src_cnt_reg < tgt_cnt_reg) ? src_cnt_reg : tgt_cnt_reg;
    assign ns_m1   = src_cnt_reg - 1'b1;
    assign nt_m1   = tgt_cnt_reg - 1'b1;
    assign i_last  = ({1'b0, i_reg} == nt_m1);
    assign j_last  = ({1'b0, j_reg} == ns_m1);
    assign query_bad = ({1'b0, query_target} >= tgt_cnt_reg);
    assign greedy_end = ev.v && (!ev.found || ((round_reg + 1'b1) == rounds));

    // Cumulative length RAMs: each load stores the running total.
    assign src_we = accept && (op == clmu_pkg::OP_LOAD_SRC) && (src_cnt_reg != CW'(MJ));
    assign tgt_we = accept && (op == clmu_pkg::OP_LOAD_TGT) && (tgt_cnt_reg != CW'(MJ));

    clmu_ram #(.DEPTH(MJ), .WIDTH(UW)) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_cnt_reg[IW-1:0]),
        .wdata (src_tot_reg + len_ext),
        .raddr (j_reg),
        .rdata (src_rdata)
    );

    clmu_ram #(.DEPTH(MJ), .WIDTH(UW)) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_cnt_reg[IW-1:0]),
        .wdata (tgt_tot_reg + len_ext),
        .raddr (i_reg),
        .rdata (tgt_rdata)
    );

    // A chain of zero total sits at position zero everywhere.
    assign ct_in = tzero_reg ? '0 : tgt_rdata;
    assign cs_in = szero_reg ? '0 : src_rdata;
    assign s_eff = szero_reg ? UW'(1) : src_tot_reg;
    assign t_eff = tzero_reg ? UW'(1) : tgt_tot_reg;

    clmu_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (tag_reg),
        .ct     (ct_in),
        .cs     (cs_in),
        .s_tot  (s_eff),
        .t_tot  (t_eff),
        .ev     (ev)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clmu_pkg::ST_IDLE:
            begin
                if (accept && (op == clmu_pkg::OP_QUERY) && !query_bad &&
                    (src_cnt_reg != tgt_cnt_reg))
                begin
                    state_next = (src_cnt_reg == '0) ? clmu_pkg::ST_FINISH
                                                     : clmu_pkg::ST_GREEDY;
                end
            end
            clmu_pkg::ST_GREEDY:
            begin
                if (greedy_end)
                begin
                    state_next = clmu_pkg::ST_LEFT;
                end
            end
            clmu_pkg::ST_LEFT:
            begin
                if (ev.v && ev.fin)
                begin
                    state_next = clmu_pkg::ST_FINISH;
                end
            end
            clmu_pkg::ST_FINISH:
            begin
                state_next = clmu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = clmu_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, scan control and result words.
    always_comb
    begin
        issuing_next  = issuing_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        round_next    = round_reg;
        tm_next       = tm_reg;
        us_next       = us_reg;
        qhas_next     = qhas_reg;
        qsrc_next     = qsrc_reg;
        pend_v_next   = pend_v_reg;
        pend_idx_next = pend_idx_reg;
        q_next        = q_reg;
        szero_next    = szero_reg;
        tzero_next    = tzero_reg;
        src_cnt_next  = src_cnt_reg;
        tgt_cnt_next  = tgt_cnt_reg;
        src_tot_next  = src_tot_reg;
        tgt_tot_next  = tgt_tot_reg;
        tag_next      = '0;
        done_next     = 1'b0;
        idx_next      = '0;
        empty_next    = 1'b0;
        err_next      = 1'b0;
        last_next     = 1'b0;
        push_v        = 1'b0;
        push_idx      = '0;

        unique case (state_reg)
            clmu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    done_next  = 1'b1;
                    last_next  = 1'b1;
                    empty_next = 1'b1;
                    unique case (op)
                        clmu_pkg::OP_LOAD_SRC:
                        begin
                            if (src_cnt_reg == CW'(MJ))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                src_cnt_next = src_cnt_reg + 1'b1;
                                src_tot_next = src_tot_reg + len_ext;
                            end
                        end
                        clmu_pkg::OP_LOAD_TGT:
                        begin
                            if (tgt_cnt_reg == CW'(MJ))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                tgt_cnt_next = tgt_cnt_reg + 1'b1;
                                tgt_tot_next = tgt_tot_reg + len_ext;
                            end
                        end
                        clmu_pkg::OP_QUERY:
                        begin
                            if (query_bad)
                            begin
                                err_next = 1'b1;
                            end
                            else if (src_cnt_reg == tgt_cnt_reg)
                            begin
                                empty_next = 1'b0;
                                idx_next   = query_target;
                            end
                            else
                            begin
                                // Long query: no word now, start the scan.
                                done_next    = 1'b0;
                                last_next    = 1'b0;
                                empty_next   = 1'b0;
                                q_next       = query_target;
                                szero_next   = (src_tot_reg == '0);
                                tzero_next   = (tgt_tot_reg == '0);
                                tm_next      = '0;
                                us_next      = '0;
                                qhas_next    = 1'b0;
                                pend_v_next  = 1'b0;
                                round_next   = '0;
                                i_next       = '0;
                                j_next       = '0;
                                issuing_next = (src_cnt_reg != '0);
                            end
                        end
                        clmu_pkg::OP_CLEAR:
                        begin
                            src_cnt_next = '0;
                            tgt_cnt_next = '0;
                            src_tot_next = '0;
                            tgt_tot_next = '0;
                        end
                        default:
                        begin
                            err_next = 1'b0;
                        end
                    endcase
                end
            end

            clmu_pkg::ST_GREEDY:
            begin
                // Target outer, source inner: ties fall to the lower indexes.
                if (issuing_reg)
                begin
                    tag_next.live     = 1'b1;
                    tag_next.consider = !tm_reg[i_reg] && !us_reg[j_reg];
                    tag_next.first    = (i_reg == '0) && (j_reg == '0);
                    tag_next.endj     = i_last && j_last;
                    tag_next.fin      = i_last && j_last;
                    tag_next.i        = i_reg;
                    tag_next.j        = j_reg;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            issuing_next = 1'b0;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                // End of a round: take the best free pair.
                if (ev.v)
                begin
                    if (ev.found)
                    begin
                        tm_next[ev.bi] = 1'b1;
                        us_next[ev.bj] = 1'b1;
                        if (ev.bi == q_reg)
                        begin
                            qhas_next = 1'b1;
                            qsrc_next = ev.bj;
                        end
                    end
                    round_next   = round_reg + 1'b1;
                    issuing_next = 1'b1;
                    i_next       = '0;
                    j_next       = '0;
                    if (greedy_end)
                    begin
                        push_v   = qhas_next;
                        push_idx = qsrc_next;
                    end
                end
            end

            clmu_pkg::ST_LEFT:
            begin
                // Source outer, target inner: nearest matched target per source.
                if (issuing_reg)
                begin
                    tag_next.live     = 1'b1;
                    tag_next.consider = tm_reg[i_reg] && !us_reg[j_reg];
                    tag_next.first    = (i_reg == '0);
                    tag_next.endj     = i_last;
                    tag_next.fin      = i_last && j_last;
                    tag_next.i        = i_reg;
                    tag_next.j        = j_reg;
                    if (i_last)
                    begin
                        i_next = '0;
                        if (j_last)
                        begin
                            issuing_next = 1'b0;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                if (ev.v && ev.found && (ev.bi == q_reg))
                begin
                    push_v   = 1'b1;
                    push_idx = ev.j;
                end
            end

            clmu_pkg::ST_FINISH:
            begin
                // Final word: the held result, or the empty marker.
                done_next    = 1'b1;
                last_next    = 1'b1;
                issuing_next = 1'b0;
                if (pend_v_reg)
                begin
                    idx_next = pend_idx_reg;
                end
                else
                begin
                    empty_next = 1'b1;
                end
                pend_v_next = 1'b0;
            end

            default:
            begin
                issuing_next = 1'b0;
            end
        endcase

        // Results go out one behind, so the final one can carry last.
        if (push_v)
        begin
            if (pend_v_reg)
            begin
                done_next = 1'b1;
                idx_next  = pend_idx_reg;
            end
            pend_v_next   = 1'b1;
            pend_idx_next = push_idx;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= clmu_pkg::ST_IDLE;
            issuing_reg <= 1'b0;
            round_reg   <= '0;
            tm_reg      <= '0;
            us_reg      <= '0;
            qhas_reg    <= 1'b0;
            pend_v_reg  <= 1'b0;
            src_cnt_reg <= '0;
            tgt_cnt_reg <= '0;
            src_tot_reg <= '0;
            tgt_tot_reg <= '0;
            tag_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            round_reg   <= round_next;
            tm_reg      <= tm_next;
            us_reg      <= us_next;
            qhas_reg    <= qhas_next;
            pend_v_reg  <= pend_v_next;
            src_cnt_reg <= src_cnt_next;
            tgt_cnt_reg <= tgt_cnt_next;
            src_tot_reg <= src_tot_next;
            tgt_tot_reg <= tgt_tot_next;
            tag_reg     <= tag_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        qsrc_reg     <= qsrc_next;
        pend_idx_reg <= pend_idx_next;
        q_reg        <= q_next;
        szero_reg    <= szero_next;
        tzero_reg    <= tzero_next;
        idx_reg      <= idx_next;
        empty_reg    <= empty_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
    end

    assign done        = done_reg;
    assign joint_index = idx_reg;
    assign empty_res   = empty_reg;
    assign error       = err_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

>>> sv/clmu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Stand-alone; no package needed.
`default_nettype none
module clmu_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 20,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> sv/clmu_dist.sv
// Distance pipeline: cross products, absolute difference and running minimum.
// Depends on clmu_pkg.
`default_nettype none
module clmu_dist (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire clmu_pkg::tag_t              tag_in,
    input  wire logic [clmu_pkg::CUM_W-1:0]  ct,
    input  wire logic [clmu_pkg::CUM_W-1:0]  cs,
    input  wire logic [clmu_pkg::CUM_W-1:0]  s_tot,
    input  wire logic [clmu_pkg::CUM_W-1:0]  t_tot,
    output clmu_pkg::scan_ev_t               ev
);

    clmu_pkg::tag_t                   tag_reg;
    logic [clmu_pkg::PROD_W-1:0]      pt_reg;
    logic [clmu_pkg::PROD_W-1:0]      ps_reg;
    logic                             found_reg;
    logic                             found_next;
    logic [clmu_pkg::PROD_W-1:0]      bd_reg;
    logic [clmu_pkg::PROD_W-1:0]      bd_next;
    logic [clmu_pkg::IDX_W-1:0]       bi_reg;
    logic [clmu_pkg::IDX_W-1:0]       bi_next;
    logic [clmu_pkg::IDX_W-1:0]       bj_reg;
    logic [clmu_pkg::IDX_W-1:0]       bj_next;
    logic [clmu_pkg::PROD_W-1:0]      d;
    logic                             f;
    logic                             take;
    clmu_pkg::scan_ev_t               ev_reg;
    clmu_pkg::scan_ev_t               ev_next;

    // Product stage: both cross products of the pair.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= ct * s_tot;
        ps_reg <= cs * t_tot;
    end

    // Compare stage: strict less-than keeps the earliest pair on ties.
    always_comb
    begin
        d          = (pt_reg >= ps_reg) ? (pt_reg - ps_reg) : (ps_reg - pt_reg);
        f          = tag_reg.first ? 1'b0 : found_reg;
        take       = tag_reg.consider && (!f || (d < bd_reg));
        found_next = take ? 1'b1 : f;
        bd_next    = take ? d : bd_reg;
        bi_next    = take ? tag_reg.i : bi_reg;
        bj_next    = take ? tag_reg.j : bj_reg;
        ev_next.v     = tag_reg.live && tag_reg.endj;
        ev_next.fin   = tag_reg.fin;
        ev_next.found = found_next;
        ev_next.bi    = bi_next;
        ev_next.bj    = bj_next;
        ev_next.j     = tag_reg.j;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            ev_reg    <= '0;
        end
        else
        begin
            ev_reg <= ev_next;
            if (tag_reg.live)
            begin
                found_reg <= found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg.live)
        begin
            bd_reg <= bd_next;
            bi_reg <= bi_next;
            bj_reg <= bj_next;
        end
    end

    assign ev = ev_reg;

endmodule
`default_nettype wire

>>> sv/clmu_checker.sv
// Port-level checks for the chain joint length matcher, bound to the top.
// Depends on clmu_pkg and chain_joint_length_matcher_unit.
`default_nettype none
module clmu_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic [1:0]                 operation,
    input wire logic                       done,
    input wire logic [clmu_pkg::IDX_W-1:0] joint_index,
    input wire logic                       empty_res,
    input wire logic                       error,
    input wire logic                       last
);

    // An error word is a lone empty word.
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        done && error |-> empty_res && last)
        else $error("error word without empty or last");

    // Empty words always close their command.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty_res |-> last && (joint_index == '0))
        else $error("empty word not final or index not zero");

    // Loads and clears answer in the next cycle.
    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation != clmu_pkg::OP_QUERY) |=> done && last)
        else $error("load or clear not acknowledged");

    // More words are due after one that is not final.
    a_more_due: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> busy)
        else $error("non-final word while idle");

endmodule

bind chain_joint_length_matcher_unit clmu_checker u_clmu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .joint_index (joint_index),
    .empty_res   (empty_res),
    .error       (error),
    .last        (last)
);
`default_nettype wire

>>> bench/chain_joint_length_matcher_unit_test.sv
// Self-checking bench for chain_joint_length_matcher_unit: directed and random words.
// It depends on clmu_pkg and the top level; a greedy matcher model predicts each result.
`timescale 1ns / 1ps
module chain_joint_length_matcher_unit_test;

    localparam int LIMIT = 4000000;

    typedef struct {
        logic [3:0] idx;
        bit         empty;
        bit         err;
        bit         last;
    } match_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [15:0] segment_length;
    logic [3:0]  query_target;
    logic        done;
    logic [3:0]  joint_index;
    logic        empty_res;
    logic        error;
    logic        last;

    // Local copy of the chains.
    longint unsigned src_len[16];
    longint unsigned tgt_len[16];
    int              src_cnt;
    int              tgt_cnt;
    longint unsigned src_sum;
    longint unsigned tgt_sum;

    match_word_t pending_matches[$];
    int          words_sent;
    int          queries_sent;
    int          results_seen;
    int          mismatches;
    int          cycles;
    bit          calm;

    chain_joint_length_matcher_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .segment_length(segment_length),
        .query_target(query_target), .done(done), .joint_index(joint_index),
        .empty_res(empty_res), .error(error), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_match(logic [3:0] idx, bit empty, bit err, bit lst);
        match_word_t w;
        w.idx = idx;
        w.empty = empty;
        w.err = err;
        w.last = lst;
        pending_matches = {pending_matches, w};
    endtask

    // Distance between a target and a source position, as a cross product.
    function automatic longint unsigned cross_dist(longint unsigned t, longint unsigned s,
                                                   longint unsigned bs, longint unsigned bt);
        longint unsigned a;
        longint unsigned b;
        a = t * bs;
        b = s * bt;
        return (a >= b) ? a - b : b - a;
    endfunction

    // Greedy one to one matching, then leftovers join their nearest target.
    task automatic predict_query(int q);
        longint unsigned cs[16];
        longint unsigned ct[16];
        int              map_t[16];
        bit              used_s[16];
        longint unsigned bs;
        longint unsigned bt;
        longint unsigned acc;
        longint unsigned d;
        longint unsigned bd;
        int              bi;
        int              bj;
        int              n;
        int              rounds;
        bs = src_sum;
        bt = tgt_sum;
        acc = 0;
        for (int j = 0; j < src_cnt; j++)
        begin
            acc += src_len[j];
            cs[j] = (bs == 0) ? 0 : acc;
        end
        acc = 0;
        for (int i = 0; i < tgt_cnt; i++)
        begin
            acc += tgt_len[i];
            ct[i] = (bt == 0) ? 0 : acc;
        end
        if (bs == 0) bs = 1;
        if (bt == 0) bt = 1;
        for (int i = 0; i < 16; i++)
        begin
            map_t[i] = -1;
            used_s[i] = 1'b0;
        end
        rounds = (src_cnt < tgt_cnt) ? src_cnt : tgt_cnt;
        for (int r = 0; r < rounds; r++)
        begin
            bi = -1;
            bj = -1;
            bd = 0;
            for (int i = 0; i < tgt_cnt; i++)
            begin
                if (map_t[i] != -1) continue;
                for (int j = 0; j < src_cnt; j++)
                begin
                    if (used_s[j]) continue;
                    d = cross_dist(ct[i], cs[j], bs, bt);
                    if (bi < 0 || d < bd)
                    begin
                        bd = d;
                        bi = i;
                        bj = j;
                    end
                end
            end
            if (bi < 0) break;
            map_t[bi] = bj;
            used_s[bj] = 1'b1;
        end
        n = 0;
        if (map_t[q] != -1)
        begin
            push_match(map_t[q][3:0], 0, 0, 0);
            n++;
        end
        for (int j = 0; j < src_cnt; j++)
        begin
            if (used_s[j]) continue;
            bi = -1;
            bd = 0;
            for (int i = 0; i < tgt_cnt; i++)
            begin
                if (map_t[i] == -1) continue;
                d = cross_dist(ct[i], cs[j], bs, bt);
                if (bi < 0 || d < bd)
                begin
                    bd = d;
                    bi = i;
                end
            end
            if (bi == q && n < 16)
            begin
                push_match(j[3:0], 0, 0, 0);
                n++;
            end
        end
        if (n == 0)
            push_match(4'd0, 1, 0, 1);
        else
            pending_matches[pending_matches.size() - 1].last = 1'b1;
    endtask

    // Update the local chains for one accepted word and queue its results.
    task automatic predict_word(clmu_pkg::op_t op, logic [15:0] len, logic [3:0] q);
        case (op)
            clmu_pkg::OP_LOAD_SRC:
            begin
                if (src_cnt >= 16)
                    push_match(4'd0, 1, 1, 1);
                else
                begin
                    src_len[src_cnt] = len;
                    src_cnt++;
                    src_sum += len;
                    push_match(4'd0, 1, 0, 1);
                end
            end
            clmu_pkg::OP_LOAD_TGT:
            begin
                if (tgt_cnt >= 16)
                    push_match(4'd0, 1, 1, 1);
                else
                begin
                    tgt_len[tgt_cnt] = len;
                    tgt_cnt++;
                    tgt_sum += len;
                    push_match(4'd0, 1, 0, 1);
                end
            end
            clmu_pkg::OP_QUERY:
            begin
                queries_sent++;
                if (int'(q) >= tgt_cnt)
                    push_match(4'd0, 1, 1, 1);
                else if (src_cnt == tgt_cnt)
                    push_match(q, 0, 0, 1);
                else
                    predict_query(int'(q));
            end
            default:
            begin
                src_cnt = 0;
                tgt_cnt = 0;
                src_sum = 0;
                tgt_sum = 0;
                push_match(4'd0, 1, 0, 1);
            end
        endcase
    endtask

    // Send one word; entered and left at a falling edge.
    task automatic send_word(clmu_pkg::op_t op, logic [15:0] len, logic [3:0] q);
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        operation = op;
        segment_length = len;
        query_target = q;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_word(op, len, q);
        words_sent++;
        @(negedge clk);
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        match_word_t w;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: idx %0d empty %0b error %0b last %0b",
                             joint_index, empty_res, error, last);
            end
            else
            begin
                w = pending_matches.pop_front();
                if (joint_index !== w.idx || empty_res !== w.empty ||
                    error !== w.err || last !== w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch (idx/empty/error/last): expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                                 w.idx, w.empty, w.err, w.last,
                                 joint_index, empty_res, error, last);
                end
            end
        end
    end

    // Queries on empty chains and equal counts, plus length extremes.
    task automatic test_equal_chains();
        send_word(clmu_pkg::OP_QUERY, 16'h0000, 4'd0);
        send_word(clmu_pkg::OP_LOAD_SRC, 16'h0000, 4'd0);
        send_word(clmu_pkg::OP_LOAD_SRC, 16'hFFFF, 4'd15);
        send_word(clmu_pkg::OP_LOAD_TGT, 16'hFFFF, 4'd0);
        send_word(clmu_pkg::OP_LOAD_TGT, 16'h0001, 4'd0);
        send_word(clmu_pkg::OP_QUERY, 16'hFFFF, 4'd1);
        send_word(clmu_pkg::OP_QUERY, 16'h0000, 4'd15);
    endtask

    // Unequal counts go through the greedy matcher.
    task automatic test_unequal_chains();
        send_word(clmu_pkg::OP_LOAD_SRC, 16'h5555, 4'd0);
        send_word(clmu_pkg::OP_QUERY, 16'h0000, 4'd0);
        send_word(clmu_pkg::OP_QUERY, 16'h0000, 4'd1);
        send_word(clmu_pkg::OP_CLEAR, 16'hAAAA, 4'd10);
    endtask

    // A source chain of zero total puts every source position at zero.
    task automatic test_zero_total();
        send_word(clmu_pkg::OP_LOAD_SRC, 16'h0000, 4'd0);
        send_word(clmu_pkg::OP_LOAD_SRC, 16'h0000, 4'd0);
        send_word(clmu_pkg::OP_LOAD_TGT, 16'h0005, 4'd0);
        send_word(clmu_pkg::OP_LOAD_TGT, 16'h0009, 4'd0);
        send_word(clmu_pkg::OP_LOAD_TGT, 16'h0000, 4'd0);
        send_word(clmu_pkg::OP_QUERY, 16'h0000, 4'd0);
        send_word(clmu_pkg::OP_QUERY, 16'h0000, 4'd2);
        send_word(clmu_pkg::OP_CLEAR, 16'h0000, 4'd0);
    endtask

    function automatic logic [15:0] pick_length(bit zeros);
        int r;
        if (zeros) return 16'h0000;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 5);
        if (r < 90) return $urandom_range(6, 16);
        return $urandom_range(0, 1);
    endfunction

    // Random chain sets: clear, fill both chains, query, with some noise.
    task automatic test_random_chains();
        int  ns;
        int  nt;
        int  nq;
        bit  zs;
        bit  zt;
        logic [3:0] q;
        while (words_sent < 200)
        begin
            calm = (words_sent > 90 && words_sent < 150);
            if ($urandom_range(0, 9) == 0)
                send_word(clmu_pkg::op_t'($urandom_range(0, 3)), 16'($urandom),
                          4'($urandom));
            else
            begin
                ns = pick_count();
                nt = pick_count();
                zs = ($urandom_range(0, 9) == 0);
                zt = ($urandom_range(0, 9) == 0);
                send_word(clmu_pkg::OP_CLEAR, 16'($urandom), 4'($urandom));
                for (int k = 0; k < ns; k++)
                    send_word(clmu_pkg::OP_LOAD_SRC, pick_length(zs), 4'($urandom));
                if (ns == 16 && $urandom_range(0, 1))
                    send_word(clmu_pkg::OP_LOAD_SRC, 16'($urandom), 4'($urandom));
                for (int k = 0; k < nt; k++)
                    send_word(clmu_pkg::OP_LOAD_TGT, pick_length(zt), 4'($urandom));
                if (nt == 16 && $urandom_range(0, 1))
                    send_word(clmu_pkg::OP_LOAD_TGT, 16'($urandom), 4'($urandom));
                nq = $urandom_range(1, 4);
                for (int k = 0; k < nq; k++)
                begin
                    if ($urandom_range(0, 4) == 0 || nt == 0)
                        q = 4'($urandom);
                    else
                        q = 4'($urandom_range(0, nt - 1));
                    send_word(clmu_pkg::OP_QUERY, 16'($urandom), q);
                end
            end
        end
        calm = 1'b0;
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        cycles = 0;
        words_sent = 0;
        queries_sent = 0;
        results_seen = 0;
        mismatches = 0;
        calm = 1'b0;
        src_cnt = 0;
        tgt_cnt = 0;
        src_sum = 0;
        tgt_sum = 0;
        start = 1'b0;
        operation = 2'd0;
        segment_length = 16'd0;
        query_target = 4'd0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_equal_chains();
        test_unequal_chains();
        test_zero_total();
        test_random_chains();
        start = 1'b0;
        while (pending_matches.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d words (%0d queries) and checked %0d result words.",
                 words_sent, queries_sent, results_seen);
        $display("Mismatching result words: %0d.", mismatches);
        if (mismatches == 0 && pending_matches.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
